>>> rtl/rmcrc_pkg.sv
// Shared types, constants and the CRC-32C word update for the matcher.
`timescale 1ns / 1ps
`default_nettype none

package rmcrc_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned CrcWidth  = 32;

   typedef logic [WordWidth-1:0] word_type;
   typedef logic [CrcWidth-1:0]  crc_type;
   typedef logic [1:0]           count_type;

   // Relocation kind codes; code 3 is unused and hashes the word unmasked.
   typedef enum logic [1:0] {
      RELOC_NONE = 2'd0,
      RELOC_JUMP = 2'd1,
      RELOC_HALF = 2'd2
   } reloc_kind_type;

   localparam crc_type  CRC_POLY  = 32'h82F6_3B78;
   localparam crc_type  CRC_INIT  = 32'hFFFF_FFFF;
   localparam word_type JUMP_KEEP = 32'hFC00_0000;
   localparam word_type HALF_KEEP = 32'hFFFF_0000;

   // Head snapshot is taken once this many words have been hashed.
   localparam count_type HEAD_WORDS = 2'd2;

   // Reflected CRC-32C over the four bytes of a word, first byte in [31:24].
   // Purely linear in crc and word, so it flattens to a shallow XOR network.
   function automatic crc_type crc32c_word(crc_type crc, word_type word);
      crc_type c;
      c = crc;
      for (int b = 3; b >= 0; b--) begin
         c = c ^ {24'd0, word[8*b +: 8]};
         for (int i = 0; i < 8; i++) begin
            c = {1'b0, c[CrcWidth-1:1]} ^ (c[0] ? CRC_POLY : '0);
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

>>> rtl/rmcrc_if.sv
// Valid/ready channel interfaces for the matcher's request and response beats.
`timescale 1ns / 1ps
`default_nettype none

interface rmcrc_req_if;
   import rmcrc_pkg::*;
   logic           valid;
   logic           ready;
   word_type       code_word;
   logic [1:0]     reloc_kind;
   logic           last_word;

   modport source (output valid, output code_word, output reloc_kind,
                   output last_word, input ready);
   modport sink   (input valid, input code_word, input reloc_kind,
                   input last_word, output ready);
endinterface

interface rmcrc_rsp_if;
   logic valid;
   logic ready;
   logic head_match;
   logic full_match;
   logic matched;

   modport source (output valid, output head_match, output full_match,
                   output matched, input ready);
   modport sink   (input valid, input head_match, input full_match,
                   input matched, output ready);
endinterface

`default_nettype wire

>>> rtl/rmcrc_update.sv
// Relocation masking and one-word CRC-32C update.
`timescale 1ns / 1ps
`default_nettype none

module rmcrc_update
   import rmcrc_pkg::*;
(
   input  word_type   code_word,
   input  logic [1:0] reloc_kind,
   input  crc_type    crc_cur,
   output crc_type    crc_next
);

   word_type masked;

   always_comb begin
      case (reloc_kind)
         RELOC_JUMP: begin
            masked = code_word & JUMP_KEEP;
         end
         RELOC_HALF: begin
            masked = code_word & HALF_KEEP;
         end
         default: begin
            masked = code_word;
         end
      endcase
   end

   assign crc_next = crc32c_word(crc_cur, masked);

endmodule

`default_nettype wire

>>> rtl/relocation_masked_crc32c_matcher.sv
// Top level of the relocation-masked CRC-32C function matcher.
`timescale 1ns / 1ps
`default_nettype none

// Streams a function body one 32-bit word per beat (first byte in [31:24])
// with its relocation kind, clears relocated bits (jump: keep top six bits;
// high/low 16: clear low half; unused kind 3: no masking), and runs
// reflected CRC-32C over the result, most significant byte first. The CRC
// after the second word (or after the only word) is kept as the head CRC.
// The beat flagged last_word produces one response beat comparing head and
// full CRC against csr registers 0 (expected_head_crc) and 1
// (expected_full_crc), then state returns to its reset values for the next
// function; other beats produce no response. Throughput is one request beat
// per cycle unless the input stage holds off; the mask and CRC update are
// combinational between the input register and the CRC state. The response
// beat is registered: the last request beat passes the input register,
// then the response register. The input stage only holds off when a last
// beat is waiting while the response register is still occupied and not
// taken.
module relocation_masked_crc32c_matcher
   import rmcrc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   rmcrc_req_if.sink   req_bus,
   rmcrc_rsp_if.source rsp_bus,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   localparam logic CSR_HEAD = 1'b0;
   localparam logic CSR_FULL = 1'b1;

   // Configuration registers.
   crc_type exp_head_ff, exp_full_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_head_ff <= '0;
         exp_full_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HEAD: begin
               exp_head_ff <= csr_wdata;
            end
            CSR_FULL: begin
               exp_full_ff <= csr_wdata;
            end
            default: begin
               exp_head_ff <= exp_head_ff;
            end
         endcase
      end
   end

   // Input register stage.
   logic       s1_valid_ff, s1_valid_in;
   word_type   s1_word_ff;
   logic [1:0] s1_kind_ff;
   logic       s1_last_ff;

   // Response register.
   logic out_valid_ff, out_valid_in;
   logic out_head_ff, out_full_ff;

   // CRC state.
   crc_type   run_crc_ff, run_crc_in;
   crc_type   head_crc_ff, head_crc_in;
   count_type words_ff, words_in;

   logic    advance;
   logic    accept;
   crc_type crc_new;
   crc_type head_sel;
   logic    head_hit, full_hit;

   // Output register frees up when drained this cycle.
   assign advance = s1_valid_ff &&
                    (!s1_last_ff || !out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || advance;
   assign accept = req_bus.valid && req_bus.ready;
   assign s1_valid_in = accept || (s1_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_word_ff <= req_bus.code_word;
         s1_kind_ff <= req_bus.reloc_kind;
         s1_last_ff <= req_bus.last_word;
      end
   end

   rmcrc_update u_update (
      .code_word  (s1_word_ff),
      .reloc_kind (s1_kind_ff),
      .crc_cur    (run_crc_ff),
      .crc_next   (crc_new)
   );

   // Head CRC is the fresh CRC until two words are in, then the snapshot.
   assign head_sel = (words_ff == HEAD_WORDS) ? head_crc_ff : crc_new;
   assign head_hit = ((head_sel ^ CRC_INIT) == exp_head_ff);
   assign full_hit = ((crc_new ^ CRC_INIT) == exp_full_ff);

   always_comb begin
      run_crc_in  = run_crc_ff;
      head_crc_in = head_crc_ff;
      words_in    = words_ff;
      if (advance) begin
         if (s1_last_ff) begin
            run_crc_in  = CRC_INIT;
            head_crc_in = '0;
            words_in    = '0;
         end else begin
            run_crc_in = crc_new;
            if (words_ff != HEAD_WORDS) begin
               words_in = words_ff + 2'd1;
               if (words_ff == HEAD_WORDS - 2'd1) begin
                  head_crc_in = crc_new;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_crc_ff  <= CRC_INIT;
         head_crc_ff <= '0;
         words_ff    <= '0;
      end else begin
         run_crc_ff  <= run_crc_in;
         head_crc_ff <= head_crc_in;
         words_ff    <= words_in;
      end
   end

   // Response beat: loaded by a last beat, cleared when taken.
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      if (advance && s1_last_ff) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_last_ff) begin
         out_head_ff <= head_hit;
         out_full_ff <= full_hit;
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.head_match = out_head_ff;
   assign rsp_bus.full_match = out_full_ff;
   assign rsp_bus.matched    = out_head_ff && out_full_ff;

   // Word counter saturates at the head snapshot point.
   a_words_sat: assert property (@(posedge clock) disable iff (reset)
      words_ff != 2'd3)
      else $error("word count past saturation");

   // A last beat leaving the input stage always shows up as a response.
   a_last_rsp: assert property (@(posedge clock) disable iff (reset)
      advance && s1_last_ff |=> out_valid_ff)
      else $error("last beat produced no response");

   // State is back at reset values after a last beat.
   a_last_clear: assert property (@(posedge clock) disable iff (reset)
      advance && s1_last_ff |=> run_crc_ff == CRC_INIT && words_ff == 2'd0
                                && head_crc_ff == '0)
      else $error("CRC state not cleared after last beat");

   // The input stage only stalls on a last beat behind a held response.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |-> s1_last_ff && out_valid_ff && !rsp_bus.ready)
      else $error("input stage stalled without cause");

endmodule

`default_nettype wire
